// ----- design/mbrs_pkg.sv -----
// shared constants and types for the rotating bitmap sampler
`default_nettype none
package mbrs_pkg;
  localparam int SOURCE_BYTES_DEF  = 16384;
  localparam int FRACTION_BITS_DEF = 10;

  typedef enum logic [1:0] {
    MODE_GENERAL = 2'd0,
    MODE_R90     = 2'd1,
    MODE_R180    = 2'd2,
    MODE_R270    = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    REG_MODE   = 3'd0,
    REG_TRANS  = 3'd1,
    REG_WIDTH  = 3'd2,
    REG_HEIGHT = 3'd3,
    REG_COS    = 3'd4,
    REG_SIN    = 3'd5,
    REG_CX     = 3'd6,
    REG_CY     = 3'd7
  } reg_index_t;

  localparam int CFG_DATA_W = 12;
  localparam logic CMD_LOAD   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // configuration bundle handed to the pipeline
  typedef struct packed {
    mode_t              mode;
    logic               trans;
    logic [7:0]         width;
    logic [7:0]         height;
    logic signed [11:0] cos_v;
    logic signed [11:0] sin_v;
    logic signed [9:0]  cx;
    logic signed [9:0]  cy;
  } cfg_t;
endpackage
`default_nettype wire

// ----- design/mono_bitmap_rotate_sampler_core.sv -----
// top level: rotating 1-bit bitmap sampler, five-stage pipeline
//
// Input channel (in_valid/in_ready) takes one beat per cycle while in_ready
// is high: command 0 loads load_data into the source store at load_address,
// command 1 samples the destination pixel (dest_x, dest_y). Every beat yields
// exactly one output beat (out_valid/out_ready) with write_enable and
// pixel_value; loads return 0, 0.
// Throughput is one beat per clock while the output is not stalled.
// Stages: coordinate offsets, products, shift and source coordinates,
// bounds and store address, store read and bit pick.
// The whole pipeline advances together; when the receiver stalls and the
// output register is full the pipeline holds and in_ready drops, nothing is
// lost or repeated. A load writes the store at the same stage where a
// sample reads it, so store accesses keep the order of the beats.
// Reset (rst, synchronous) clears valid bits and the configuration
// registers; the store keeps its content and needs no clearing pass.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once;
// the user makes them only while the pipeline is empty, the block does not enforce it.
`default_nettype none
module mono_bitmap_rotate_sampler_core
  import mbrs_pkg::*;
#(
  parameter int SOURCE_BYTES  = SOURCE_BYTES_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  command,
  input  wire logic [13:0]           load_address,
  input  wire logic [7:0]            load_data,
  input  wire logic signed [11:0]    dest_x,
  input  wire logic signed [11:0]    dest_y,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       write_enable,
  output logic                       pixel_value,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);
  localparam int AW = $clog2(SOURCE_BYTES);

  cfg_t cfg;
  mbrs_cfg u_cfg (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .cfg
  );

  logic adv;
  logic v1, v2, v3, v4;
  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // stage 1: offsets and exact-map coordinates, load beat captured
  logic               s1_samp;
  logic signed [12:0] s1_du, s1_dv;
  logic signed [13:0] s1_col, s1_row;
  logic [13:0]        s1_la;
  logic [7:0]         s1_ld;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_samp <= command == CMD_SAMPLE;
      s1_la   <= load_address;
      s1_ld   <= load_data;
      s1_du   <= 13'(dest_x) - 13'(cfg.cx);
      s1_dv   <= 13'(dest_y) - 13'(cfg.cy);
      case (cfg.mode)
        MODE_R90: begin
          s1_col <= 14'(dest_y) - 14'(cfg.cy) + 14'(cfg.cx);
          s1_row <= 14'(cfg.cx) + 14'(cfg.cy) - 14'(dest_x);
        end
        MODE_R180: begin
          s1_col <= 14'(cfg.cx) + 14'(cfg.cx) - 14'(dest_x);
          s1_row <= 14'(cfg.cy) + 14'(cfg.cy) - 14'(dest_y);
        end
        MODE_R270: begin
          s1_col <= 14'(cfg.cx) + 14'(cfg.cy) - 14'(dest_y);
          s1_row <= 14'(dest_x) - 14'(cfg.cx) + 14'(cfg.cy);
        end
        default: begin
          s1_col <= '0;
          s1_row <= '0;
        end
      endcase
    end
  end

  // stage 2: the four products
  logic               s2_samp;
  logic signed [24:0] p_uc, p_vs, p_vc, p_us;
  logic signed [13:0] s2_col, s2_row;
  logic [13:0]        s2_la;
  logic [7:0]         s2_ld;
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_samp <= s1_samp;
      s2_la   <= s1_la;
      s2_ld   <= s1_ld;
      p_uc    <= 25'(s1_du) * 25'(cfg.cos_v);
      p_vs    <= 25'(s1_dv) * 25'(cfg.sin_v);
      p_vc    <= 25'(s1_dv) * 25'(cfg.cos_v);
      p_us    <= 25'(s1_du) * 25'(cfg.sin_v);
      s2_col  <= s1_col;
      s2_row  <= s1_row;
    end
  end

  // stage 3: sums, arithmetic shift, add centre (general mode; exact maps pass through)
  logic signed [25:0] sum_c, sum_r;
  logic               s3_samp;
  logic signed [26:0] s3_col, s3_row;
  logic [13:0]        s3_la;
  logic [7:0]         s3_ld;
  assign sum_c = 26'(p_uc) + 26'(p_vs);
  assign sum_r = 26'(p_vc) - 26'(p_us);
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_samp <= s2_samp;
      s3_la   <= s2_la;
      s3_ld   <= s2_ld;
      if (cfg.mode == MODE_GENERAL) begin
        s3_col <= 27'(sum_c >>> FRACTION_BITS) + 27'(cfg.cx);
        s3_row <= 27'(sum_r >>> FRACTION_BITS) + 27'(cfg.cy);
      end else begin
        s3_col <= 27'(s2_col);
        s3_row <= 27'(s2_row);
      end
    end
  end

  // stage 4: bounds check and byte address
  logic        inside_src;
  logic [8:0]  stride;
  logic [17:0] addr_full;
  logic [7:0]  col8, row8;
  assign col8   = s3_col[7:0];
  assign row8   = s3_row[7:0];
  assign inside_src = !s3_col[26] && !s3_row[26]
                      && s3_col < 27'(cfg.width) && s3_row < 27'(cfg.height);
  assign stride = cfg.trans ? (9'(cfg.width) + 9'd3) >> 2
                            : (9'(cfg.width) + 9'd7) >> 3;
  assign addr_full = 18'(row8) * 18'(stride)
                     + (cfg.trans ? 18'(col8 >> 2) : 18'(col8 >> 3));

  logic       s4_samp, s4_in, s4_inrange;
  logic [2:0] s4_bit;
  logic       s4_trans;
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_samp    <= s3_samp;
      s4_in      <= inside_src;
      s4_inrange <= addr_full < 18'(SOURCE_BYTES);
      s4_bit     <= col8[2:0];
      s4_trans   <= cfg.trans;
    end
  end

  // load write at the read stage, out-of-range addresses dropped
  logic ld_we;
  assign ld_we = adv && v3 && !s3_samp && 18'(s3_la) < 18'(SOURCE_BYTES);

  // store read, registered inside the ram
  logic [7:0] rbyte;
  mbrs_ram #(.WIDTH(8), .DEPTH(SOURCE_BYTES)) u_ram (
    .clk,
    .we    (ld_we),
    .waddr (AW'(s3_la)),
    .wdata (s3_ld),
    .re    (adv),
    .raddr (addr_full[AW-1:0]),
    .rdata (rbyte)
  );

  // stage 5: output register for the store byte, bit pick from it
  logic       s5_samp, s5_in, s5_inrange, s5_trans;
  logic [2:0] s5_bit;
  logic [7:0] s5_byte;
  always_ff @(posedge clk) begin
    if (adv) begin
      s5_samp    <= s4_samp;
      s5_in      <= s4_in;
      s5_inrange <= s4_inrange;
      s5_trans   <= s4_trans;
      s5_bit     <= s4_bit;
      s5_byte    <= rbyte;
    end
  end

  logic [7:0] b;
  logic       opaque, colour, raw_bit;
  assign b       = s5_inrange ? s5_byte : 8'h00;
  assign opaque  = b[3'd6 - {s5_bit[1:0], 1'b0}];
  assign colour  = b[3'd7 - {s5_bit[1:0], 1'b0}];
  assign raw_bit = b[3'd7 - s5_bit];
  assign write_enable = s5_samp && s5_in && (!s5_trans || opaque);
  assign pixel_value  = write_enable && (s5_trans ? colour : raw_bit);

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, out_valid} <= '0;
    end else if (adv) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end
endmodule
`default_nettype wire

// ----- design/mbrs_ram.sv -----
// generic single-port-write, single-port-read ram with registered read
`default_nettype none
module mbrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port, read holds when re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

// ----- design/mbrs_cfg.sv -----
// configuration register file
`default_nettype none
module mbrs_cfg
  import mbrs_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [2:0]            cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                       cfg
);
  // register writes, reset to the defaults below
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode   <= MODE_GENERAL;
      cfg.trans  <= 1'b0;
      cfg.width  <= 8'd1;
      cfg.height <= 8'd1;
      cfg.cos_v  <= 12'sd1024;
      cfg.sin_v  <= 12'sd0;
      cfg.cx     <= 10'sd0;
      cfg.cy     <= 10'sd0;
    end else if (cfg_we) begin
      case (reg_index_t'(cfg_index))
        REG_MODE:   cfg.mode   <= mode_t'(cfg_data[1:0]);
        REG_TRANS:  cfg.trans  <= cfg_data[0];
        REG_WIDTH:  cfg.width  <= cfg_data[7:0];
        REG_HEIGHT: cfg.height <= cfg_data[7:0];
        REG_COS:    cfg.cos_v  <= cfg_data;
        REG_SIN:    cfg.sin_v  <= cfg_data;
        REG_CX:     cfg.cx     <= cfg_data[9:0];
        REG_CY:     cfg.cy     <= cfg_data[9:0];
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

// ----- verif/tb.sv -----
// testbench for the rotating 1-bit bitmap sampler: directed and random beats checked in order
`default_nettype none
module tb;
  import mbrs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic command = CMD_LOAD;
  logic [13:0] load_address = '0;
  logic [7:0] load_data = '0;
  logic signed [11:0] dest_x = '0;
  logic signed [11:0] dest_y = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic write_enable;
  logic pixel_value;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  mono_bitmap_rotate_sampler_core uut (.*);

  // expected pixel beat
  typedef struct packed {
    logic we;
    logic pix;
  } pixel_t;

  // predictor state
  logic [7:0] bitmap [0:16383];
  mode_t m_mode;
  logic m_trans;
  int m_w, m_h, m_cos, m_sin, m_cx, m_cy;

  pixel_t pixel_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int beats_out = 0;
  int samples_sent = 0;
  int opaque_hits = 0;
  int rx_wait = 0;
  int rx_seen = 0;
  bit hold_off = 1'b0;
  bit rand_stall = 1'b0;

  initial forever #5 clk = ~clk;

  // receiver: with rand_stall set, a random wait drawn per beat, or a hold-off
  always @(negedge clk) begin
    int n;
    if (rst || hold_off) begin
      out_ready <= 1'b0;
    end else if (beats_out != rx_seen) begin
      rx_seen <= beats_out;
      n = rand_stall ? int'($urandom_range(0, 11)) : 0;
      out_ready <= (n == 0);
      rx_wait <= (n == 0) ? 0 : n - 1;
    end else if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait <= rx_wait - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    pixel_t exp_px;
    if (!rst && out_valid && out_ready) begin
      beats_out++;
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat we=%0b pix=%0b", write_enable,
                                       pixel_value);
      end else begin
        exp_px = pixel_q.pop_front();
        if (exp_px.we !== write_enable || exp_px.pix !== pixel_value) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected we=%0b pix=%0b got we=%0b pix=%0b",
                     exp_px.we, exp_px.pix, write_enable, pixel_value);
        end
      end
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("watchdog expired");
      $display("tb: errors");
      $finish;
    end
  end

  // source pixel lookup, (0,0) outside or transparent
  function automatic pixel_t fetch_pixel(int col, int row);
    pixel_t r;
    int addr;
    logic [7:0] b, mask;
    r = '0;
    if (col < 0 || col >= m_w || row < 0 || row >= m_h) return r;
    if (m_trans) begin
      addr = row * ((m_w + 3) >> 2) + (col >> 2);
      b = (addr < 16384) ? bitmap[addr] : 8'h00;
      mask = 8'h40 >> (2 * (col & 3));
      if (b & mask) begin
        r.we = 1'b1;
        r.pix = |(b & (mask << 1));
      end
    end else begin
      addr = row * ((m_w + 7) >> 3) + (col >> 3);
      b = (addr < 16384) ? bitmap[addr] : 8'h00;
      r.we = 1'b1;
      r.pix = |(b & (8'h80 >> (col & 7)));
    end
    return r;
  endfunction

  // inverse rotation of one destination pixel
  function automatic pixel_t rotate_sample(int u, int v);
    longint col, row, a, b;
    case (m_mode)
      MODE_R90: begin
        col = v - m_cy + m_cx;
        row = m_cx + m_cy - u;
      end
      MODE_R180: begin
        col = 2 * m_cx - u;
        row = 2 * m_cy - v;
      end
      MODE_R270: begin
        col = m_cx + m_cy - v;
        row = u - m_cx + m_cy;
      end
      default: begin
        a = longint'(u - m_cx) * m_cos + longint'(v - m_cy) * m_sin;
        b = longint'(v - m_cy) * m_cos - longint'(u - m_cx) * m_sin;
        col = (a >>> 10) + m_cx;
        row = (b >>> 10) + m_cy;
      end
    endcase
    return fetch_pixel(int'(col), int'(row));
  endfunction

  // drop valid, then wait for all results and let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // register write, only with the pipeline empty
  task automatic write_reg(reg_index_t idx, int value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CFG_DATA_W-1:0];
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_MODE: m_mode = mode_t'(value[1:0]);
      REG_TRANS: m_trans = value[0];
      REG_WIDTH: m_w = value & 8'hff;
      REG_HEIGHT: m_h = value & 8'hff;
      REG_COS: m_cos = int'(signed'(value[11:0]));
      REG_SIN: m_sin = int'(signed'(value[11:0]));
      REG_CX: m_cx = int'(signed'(value[9:0]));
      default: m_cy = int'(signed'(value[9:0]));
    endcase
  endtask

  task automatic set_view(mode_t md, bit tr, int w, int h, int cs, int sn, int cx, int cy);
    drain();
    write_reg(REG_MODE, md);
    write_reg(REG_TRANS, tr);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_COS, cs);
    write_reg(REG_SIN, sn);
    write_reg(REG_CX, cx);
    write_reg(REG_CY, cy);
  endtask

  // one input beat; gap drawn per beat, valid stays up into the next beat when no gap is drawn
  task automatic send_beat(logic cmd, int addr, int data, int u, int v, bit gaps);
    pixel_t p;
    int gap;
    gap = gaps ? int'($urandom_range(0, 11)) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    load_address <= addr[13:0];
    load_data <= data[7:0];
    dest_x <= u[11:0];
    dest_y <= v[11:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    p = '0;
    if (cmd == CMD_LOAD) begin
      bitmap[addr[13:0]] = data[7:0];
    end else begin
      p = rotate_sample(int'(signed'(u[11:0])), int'(signed'(v[11:0])));
      samples_sent++;
      if (p.we) opaque_hits++;
    end
    pixel_q.push_back(p);
    @(negedge clk);
  endtask

  // fill store addresses 0 to bytes-1 with random bytes
  task automatic load_bitmap(int bytes, bit gaps);
    for (int i = 0; i < bytes; i++) send_beat(CMD_LOAD, i, $urandom_range(0, 255), 0, 0, gaps);
  endtask

  task automatic test_directed();
    load_bitmap(64, 1'b0);
    set_view(MODE_GENERAL, 1'b0, 1, 1, 1024, 0, 0, 0);
    send_beat(CMD_SAMPLE, 0, 0, 0, 0, 1'b0);
    send_beat(CMD_SAMPLE, 0, 0, -2048, 2047, 1'b0);
    send_beat(CMD_SAMPLE, 0, 0, 2047, -2048, 1'b0);
    send_beat(CMD_LOAD, 16383, 8'hff, 0, 0, 1'b0);
    send_beat(CMD_LOAD, 16383, 8'h00, 0, 0, 1'b0);
    set_view(MODE_GENERAL, 1'b0, 16, 16, -1024, 1024, 8, 8);
    for (int i = 0; i < 4; i++) send_beat(CMD_SAMPLE, 0, 0, i * 5, 15 - i * 3, 1'b0);
    set_view(MODE_GENERAL, 1'b0, 16, 16, 2047, -2048, 0, 0);
    send_beat(CMD_SAMPLE, 0, 0, 1, 0, 1'b0);
    send_beat(CMD_SAMPLE, 0, 0, -1, -1, 1'b0);
    for (int md = 1; md < 4; md++) begin
      set_view(mode_t'(md), md[0], 16, 16, 0, 0, 7, 7);
      for (int i = 0; i < 4; i++) send_beat(CMD_SAMPLE, 0, 0, i * 4, 14 - i * 4, 1'b0);
    end
  endtask

  // random view, a load of its source region, then a burst of samples, most of them near it
  task automatic test_random(int rounds);
    int w, h, stride;
    for (int r = 0; r < rounds; r++) begin
      w = (r % 9 == 0) ? 255 : $urandom_range(1, 24);
      h = (r % 9 == 0) ? 2 : $urandom_range(1, 24);
      if (r % 13 == 5) begin
        w = $urandom_range(1, 8);
        h = 255;
      end
      set_view(mode_t'($urandom_range(0, 3)), $urandom_range(0, 1), w, h,
               $urandom_range(0, 2048) - 1024, $urandom_range(0, 2048) - 1024,
               (r % 7 == 3) ? ((r & 1) ? 511 : -512) : $urandom_range(0, 24) - 4,
               (r % 7 == 3) ? ((r & 1) ? -512 : 511) : $urandom_range(0, 24) - 4);
      stride = m_trans ? (w + 3) >> 2 : (w + 7) >> 3;
      rand_stall = $urandom_range(0, 3) != 0;
      load_bitmap(stride * h, $urandom_range(0, 1));
      for (int i = 0; i < 20; i++) begin
        if ($urandom_range(0, 9) == 0)
          send_beat(CMD_SAMPLE, $urandom_range(0, 16383), $urandom_range(0, 255),
                    $urandom_range(0, 4095) - 2048, $urandom_range(0, 4095) - 2048, 1'b1);
        else
          send_beat(CMD_SAMPLE, $urandom_range(0, 16383), $urandom_range(0, 255),
                    $urandom_range(0, w + 20) - 10, $urandom_range(0, h + 20) - 10,
                    rand_stall);
      end
    end
  endtask

  // receiver holds off while the sender keeps offering beats
  task automatic test_backpressure();
    set_view(MODE_R180, 1'b0, 16, 16, 0, 0, 8, 8);
    hold_off = 1'b1;
    fork
      begin
        repeat (60) @(negedge clk);
        hold_off = 1'b0;
      end
      for (int i = 0; i < 30; i++)
        send_beat(CMD_SAMPLE, 0, 0, $urandom_range(0, 16), $urandom_range(0, 16), 1'b0);
    join
    drain();
  endtask

  initial begin
    for (int i = 0; i < 16384; i++) begin
      bitmap[i] = 8'h00;
    end
    m_mode = MODE_GENERAL;
    m_trans = 1'b0;
    m_w = 1;
    m_h = 1;
    m_cos = 1024;
    m_sin = 0;
    m_cx = 0;
    m_cy = 0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_backpressure();
    test_random(11);
    drain();
    $display("covered %0d samples (%0d opaque) and %0d beats out, all modes and views",
             samples_sent, opaque_hits, beats_out);
    if (mismatches == 0 && pixel_q.size() == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule
`default_nettype wire
